// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)

`endif

`endif

// ===== rtl/ngrf_pkg.sv =====
// ----------------------------------------------------------------------------
// ngrf_pkg
// shared constants and types of the ng-route feasibility check
// ----------------------------------------------------------------------------
`default_nettype none

package ngrf_pkg;

    localparam int NUM_VERTICES = 64;
    localparam int MAX_ROUTES   = 65536;

    localparam int VERTEX_W = 6;
    localparam int NB_W     = 64;
    localparam int ROUTE_W  = 16;
    localparam int ADDR_W   = $clog2(NUM_VERTICES);
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // operation codes of an input item
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ROUTE = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_FULL_MEMORY = 1'b0;
    localparam logic REG_FIRST_ROUTE = 1'b1;

    typedef logic [VERTEX_W-1:0] vertex_t;
    typedef logic [NB_W-1:0]     nb_t;
    typedef logic [ROUTE_W-1:0]  route_t;

    // route vertex waiting for its table word
    typedef struct packed {
        vertex_t vertex;
        logic    last;
        logic    in_range;
    } stage_t;

endpackage

`default_nettype wire

// ===== rtl/ngrf_ram.sv =====
// ----------------------------------------------------------------------------
// ngrf_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module ngrf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ng_route_feasibility_check.sv =====
// ----------------------------------------------------------------------------
// ng_route_feasibility_check
// flags routes that revisit a vertex held in ng-route memory
// ----------------------------------------------------------------------------
// input channel (in_valid / in_ready) carries one item per vertex: a load item
// writes the neighbourhood word of a vertex into the table, a route item
// visits a vertex. the route item with last set closes the route and yields
// one item on the output channel (out_valid / out_ready) with the route index
// and the remove flag.
// a closing item is held in the stage register and then in the output register.
// throughput is one item per cycle while the receiver does not stall: the table
// read of one item overlaps the path memory update of the item before it.
// a stalled receiver holds a closing route item in the stage behind the table
// read; non-closing items and loads keep flowing until that item is stuck.
// reset clears the path memory, the flag, the route counter and the two
// registers; the table stays undefined until loaded, with no clearing pass.
// registers via apb at 0x0 (full_memory) and 0x4 (first_route) must be written
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ng_route_feasibility_check (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // apb
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ngrf_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [ngrf_pkg::PDATA_W-1:0]  pwdata,
    output logic      [ngrf_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    // input items
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          operation,
    input  wire logic [ngrf_pkg::VERTEX_W-1:0] vertex,
    input  wire logic [ngrf_pkg::NB_W-1:0]     neighbourhood,
    input  wire logic                          last,
    // result items
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [ngrf_pkg::ROUTE_W-1:0]  route_index,
    output logic                               remove
);

    import ngrf_pkg::*;

    logic    full_memory_reg;
    route_t  first_route_reg;

    logic    s1_valid_reg, s1_valid_next;
    stage_t  s1_reg, s1_next;

    nb_t     path_reg, path_next;
    logic    flagged_reg, flagged_next;
    route_t  counter_reg, counter_next;

    logic    out_valid_reg, out_valid_next;
    route_t  route_index_reg, route_index_next;
    logic    remove_reg, remove_next;

    logic    in_accept;
    logic    s1_fire;
    logic    cfg_write;
    logic    ram_we;
    logic    ram_re;
    nb_t     ram_rdata;
    nb_t     entry;
    nb_t     vbit;
    logic    hit;
    logic    vertex_in_range;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_memory_reg <= 1'b0;
            first_route_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_FULL_MEMORY: full_memory_reg <= pwdata[0];
                REG_FIRST_ROUTE: first_route_reg <= pwdata[ROUTE_W-1:0];
                default:         full_memory_reg <= full_memory_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FULL_MEMORY: prdata = {{(PDATA_W-1){1'b0}}, full_memory_reg};
            REG_FIRST_ROUTE: prdata = {{(PDATA_W-ROUTE_W){1'b0}}, first_route_reg};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshake and table access
    // ------------------------------------------------------------------
    // a closing item may leave stage 1 only when the output register frees
    assign s1_fire   = s1_valid_reg & (~s1_reg.last | ~out_valid_reg | out_ready);
    assign in_ready  = ~s1_valid_reg | s1_fire;
    assign in_accept = in_valid & in_ready;

    assign vertex_in_range = ({1'b0, vertex} < (VERTEX_W+1)'(NUM_VERTICES));

    assign ram_we = in_accept & (operation == OP_LOAD) & vertex_in_range;
    assign ram_re = in_accept & (operation == OP_ROUTE);

    ngrf_ram #(
        .WIDTH (NB_W),
        .DEPTH (NUM_VERTICES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (vertex[ADDR_W-1:0]),
        .wdata (neighbourhood),
        .re    (ram_re),
        .raddr (vertex[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        if (in_ready)
        begin
            s1_valid_next = ram_re;
        end
        if (ram_re)
        begin
            s1_next.vertex   = vertex;
            s1_next.last     = last;
            s1_next.in_range = vertex_in_range;
        end
    end

    // ------------------------------------------------------------------
    // path memory update
    // ------------------------------------------------------------------
    assign entry = s1_reg.in_range ? ram_rdata : '0;
    assign vbit  = nb_t'(1) << s1_reg.vertex;
    assign hit   = |(path_reg & vbit);

    always_comb
    begin
        path_next        = path_reg;
        flagged_next     = flagged_reg;
        counter_next     = counter_reg;
        out_valid_next   = out_valid_reg & ~out_ready;
        route_index_next = route_index_reg;
        remove_next      = remove_reg;
        if (s1_fire)
        begin
            if (!flagged_reg)
            begin
                if (hit)
                begin
                    flagged_next = 1'b1;
                end
                else
                begin
                    path_next = (full_memory_reg ? path_reg : (path_reg & entry)) | vbit;
                end
            end
            if (s1_reg.last)
            begin
                out_valid_next   = 1'b1;
                route_index_next = counter_reg;
                remove_next      = (flagged_reg | hit) & (counter_reg >= first_route_reg);
                path_next        = '0;
                flagged_next     = 1'b0;
                counter_next     = (counter_reg == ROUTE_W'(MAX_ROUTES - 1)) ?
                                   '0 : counter_reg + ROUTE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            path_reg      <= '0;
            flagged_reg   <= 1'b0;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            path_reg      <= path_next;
            flagged_reg   <= flagged_next;
            counter_reg   <= counter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg          <= s1_next;
        route_index_reg <= route_index_next;
        remove_reg      <= remove_next;
    end

    assign out_valid   = out_valid_reg;
    assign route_index = route_index_reg;
    assign remove      = remove_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_close_gives_result, clk, rst_n, (s1_fire && s1_reg.last) |=> out_valid)
    `ASSERT_CLK(a_close_clears_path, clk, rst_n, (s1_fire && s1_reg.last) |=> (path_reg == '0 && !flagged_reg))
    `ASSERT_CLK(a_remove_above_first, clk, rst_n, (out_valid && remove) |-> (route_index >= first_route_reg))
    `ASSERT_NEVER(a_no_accept_on_stall, clk, rst_n, in_ready && s1_valid_reg && !s1_fire)

endmodule

`default_nettype wire

// ===== bench/ng_route_feasibility_check_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ng_route_feasibility_check_test
// streams neighbourhood loads and route vertices into the checker, predicts
// every route verdict from a local copy of the table and path memory, and
// compares each result item in order while both channels stall at random in
// every phase but one
module ng_route_feasibility_check_test;
    import ngrf_pkg::*;

    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS   = 300;

    typedef struct packed {
        route_t index;
        logic   remove;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic    in_valid = 1'b0;
    logic    in_ready;
    logic    operation = OP_LOAD;
    vertex_t vertex = '0;
    nb_t     neighbourhood = '0;
    logic    last = 1'b0;

    logic    out_valid;
    logic    out_ready = 1'b0;
    route_t  route_index;
    logic    remove;

    // local copy of the block state
    nb_t    ng_table [NUM_VERTICES];
    nb_t    visit_mask = '0;
    logic   route_hit = 1'b0;
    route_t route_count = '0;
    logic   keep_all = 1'b0;
    route_t first_checked = '0;

    verdict_t    verdicts_due [$];
    int          errors = 0;
    int          items_sent = 0;
    bit          gaps_on = 1'b1;
    int unsigned cycle_count = 0;

    ng_route_feasibility_check DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .vertex        (vertex),
        .neighbourhood (neighbourhood),
        .last          (last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .route_index   (route_index),
        .remove        (remove)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic void predict_verdict(logic op, vertex_t v, nb_t nb, logic lst);
        nb_t v_bit;
        v_bit = nb_t'(1) << v;
        if (op == OP_LOAD)
        begin
            ng_table[v] = nb;
            return;
        end
        if (!route_hit)
        begin
            if ((visit_mask & v_bit) != '0)
                route_hit = 1'b1;
            else
            begin
                if (!keep_all)
                    visit_mask &= ng_table[v];
                visit_mask |= v_bit;
            end
        end
        if (lst)
        begin
            verdicts_due.push_back(verdict_t'{route_count,
                                              route_hit && (route_count >= first_checked)});
            route_count = route_count + 1'b1;
            visit_mask = '0;
            route_hit = 1'b0;
        end
    endfunction

    function automatic void check_verdict(route_t idx, logic rm);
        verdict_t want;
        if (verdicts_due.size() == 0)
        begin
            errors++;
            if (errors <= 200)
                $display("%0t: result with no route pending, route_index %0d remove %0b",
                         $time, idx, rm);
            return;
        end
        want = verdicts_due.pop_front();
        if (idx !== want.index)
        begin
            errors++;
            if (errors <= 200)
                $display("%0t: route_index expected %0d actual %0d", $time, want.index, idx);
        end
        if (rm !== want.remove)
        begin
            errors++;
            if (errors <= 200)
                $display("%0t: remove of route %0d expected %0b actual %0b",
                         $time, want.index, want.remove, rm);
        end
    endfunction

    function automatic nb_t random_ng_word();
        case ($urandom_range(0, 4))
            0: return '1;
            1: return '0;
            2: return {$urandom, $urandom};
            default: return {$urandom, $urandom} | {$urandom, $urandom};
        endcase
    endfunction

    // result side: ready drops for a drawn number of cycles with a result waiting
    initial
    begin : result_sink
        int stall_left;
        bit took;
        bit waiting;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            took = out_valid && out_ready;
            waiting = out_valid && !took;
            if (took)
                check_verdict(route_index, remove);
            @(posedge clk);
            if (took)
                stall_left = gaps_on ? $urandom_range(0, 7) : 0;
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                if (waiting)
                    stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // valid stays high across back-to-back items, so it is only lowered for a gap
    task automatic send_item(logic op, vertex_t v, nb_t nb, logic lst);
        int gap;
        bit took;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        operation     <= op;
        vertex        <= v;
        neighbourhood <= nb;
        last          <= lst;
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end while (!took);
        predict_verdict(op, v, nb, lst);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_FULL_MEMORY)
            keep_all = value[0];
        else
            first_checked = value[ROUTE_W-1:0];
    endtask

    task automatic send_route_vertex(vertex_t v, logic lst);
        send_item(OP_ROUTE, v, {$urandom, $urandom}, lst);
    endtask

    task automatic test_ng_basics();
        send_item(OP_LOAD, 6'd0, '1, 1'b0);
        send_item(OP_LOAD, 6'd63, '0, 1'b0);
        send_item(OP_LOAD, 6'd5, 64'h1, 1'b0);
        // last on a load gives no result
        send_item(OP_LOAD, 6'd9, {$urandom, $urandom}, 1'b1);
        // vertex 5 keeps vertex 0 in memory, so the return is caught
        send_route_vertex(6'd0, 1'b0);
        send_route_vertex(6'd5, 1'b0);
        send_route_vertex(6'd0, 1'b1);
        // vertex 63 forgets everything, so the return is allowed
        send_route_vertex(6'd0, 1'b0);
        send_route_vertex(6'd63, 1'b0);
        send_route_vertex(6'd0, 1'b1);
        send_route_vertex(6'd63, 1'b0);
        send_route_vertex(6'd63, 1'b1);
        // table rewritten in the middle of a route
        send_route_vertex(6'd0, 1'b0);
        send_item(OP_LOAD, 6'd63, '1, 1'b0);
        send_route_vertex(6'd63, 1'b0);
        send_route_vertex(6'd0, 1'b1);
    endtask

    task automatic test_full_memory();
        wait_idle();
        write_reg(REG_FULL_MEMORY, 32'd1);
        // vertex 5 would drop vertex 9 under ng memory
        send_route_vertex(6'd9, 1'b0);
        send_route_vertex(6'd5, 1'b0);
        send_route_vertex(6'd9, 1'b1);
        send_route_vertex(6'd0, 1'b0);
        send_route_vertex(6'd63, 1'b0);
        send_route_vertex(6'd5, 1'b1);
        wait_idle();
        write_reg(REG_FULL_MEMORY, 32'd0);
    endtask

    task automatic test_first_route();
        wait_idle();
        write_reg(REG_FIRST_ROUTE, PDATA_W'(route_t'(route_count + 2'd2)));
        repeat (3)
        begin
            send_route_vertex(6'd0, 1'b0);
            send_route_vertex(6'd0, 1'b1);
        end
        wait_idle();
        write_reg(REG_FIRST_ROUTE, 32'd0);
    endtask

    task automatic test_first_route_max();
        wait_idle();
        write_reg(REG_FIRST_ROUTE, 32'hFFFF);
        // revisiting routes all lie below the top index, so none is removed
        repeat (12)
        begin
            send_route_vertex(6'd9, 1'b0);
            send_route_vertex(6'd9, 1'b1);
        end
        wait_idle();
        write_reg(REG_FIRST_ROUTE, 32'd0);
    endtask

    task automatic test_random_routes();
        int target;
        int len;
        int base;
        bit narrow;
        vertex_t v;
        wait_idle();
        for (int i = 0; i < NUM_VERTICES; i++)
            send_item(OP_LOAD, vertex_t'(i), random_ng_word(), 1'($urandom_range(0, 1)));
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            write_reg(REG_FULL_MEMORY, (phase == 2) ? 32'd1 : 32'd0);
            case (phase)
                1: write_reg(REG_FIRST_ROUTE,
                             PDATA_W'(route_t'(route_count + $urandom_range(5, 30))));
                3: write_reg(REG_FIRST_ROUTE, PDATA_W'(route_count));
                default: write_reg(REG_FIRST_ROUTE, 32'd0);
            endcase
            gaps_on = (phase != 1);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_item(OP_LOAD, vertex_t'($urandom), random_ng_word(),
                              1'($urandom_range(0, 1)));
                end
                else
                begin
                    len = $urandom_range(1, 10);
                    narrow = $urandom_range(0, 2) != 0;
                    base = $urandom_range(0, NUM_VERTICES - 8);
                    for (int k = 0; k < len; k++)
                    begin
                        if ($urandom_range(0, 11) == 0)
                            send_item(OP_LOAD, vertex_t'($urandom), random_ng_word(),
                                      1'($urandom_range(0, 1)));
                        if (narrow)
                            v = vertex_t'(base + $urandom_range(0, 7));
                        else
                            v = vertex_t'($urandom);
                        send_route_vertex(v, k == len - 1);
                    end
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_reg(REG_FULL_MEMORY, 32'd0);
        write_reg(REG_FIRST_ROUTE, 32'd0);
        test_ng_basics();
        test_full_memory();
        test_first_route();
        test_first_route_max();
        test_random_routes();
        wait_idle();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== ng_route_feasibility_check.f =====
+incdir+rtl
rtl/ngrf_pkg.sv
rtl/ngrf_ram.sv
rtl/ng_route_feasibility_check.sv
bench/ng_route_feasibility_check_test.sv
